// ===== hw/rtl/p2rgb_pkg.sv =====
// Package for the pixel to RGB converter: palette sizing, register codes,
// channel scaling and color types. No dependencies.
package p2rgb_pkg;

   localparam int PALETTE_DEPTH = 256;
   localparam int PAL_IDX_W = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;
   localparam int PAL_CNT_W = $clog2(PALETTE_DEPTH + 1);

   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 32;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_DIRECT_MODE = 3'd0,
      CSR_RED_FIELD   = 3'd1,
      CSR_GREEN_FIELD = 3'd2,
      CSR_BLUE_FIELD  = 3'd3,
      CSR_COLOR_COUNT = 3'd4
   } csr_reg_type;

   // Per-channel scaling derived from a mask when it is written.
   typedef struct packed {
      logic [4:0] shift;
      logic [7:0] top;
      logic [7:0] scale;
   } chan_cfg_type;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } rgb_type;

   // Derived values for the reset masks 00FF0000, 0000FF00, 000000FF.
   localparam chan_cfg_type RED_CHAN_RESET   = '{shift: 5'd16, top: 8'hFF, scale: 8'd1};
   localparam chan_cfg_type GREEN_CHAN_RESET = '{shift: 5'd8,  top: 8'hFF, scale: 8'd1};
   localparam chan_cfg_type BLUE_CHAN_RESET  = '{shift: 5'd0,  top: 8'hFF, scale: 8'd1};

   localparam rgb_type RGB_BLACK = '{red: 8'h00, green: 8'h00, blue: 8'h00};
   localparam rgb_type RGB_WHITE = '{red: 8'hFF, green: 8'hFF, blue: 8'hFF};

endpackage

// ===== hw/rtl/p2rgb_if.sv =====
// Handshake interfaces for the pixel to RGB converter: request and response.
// Depends on nothing; payload widths are fixed by the item fields.
interface p2rgb_req_if;
   logic        valid;
   logic        ready;
   logic        kind;
   logic [31:0] pixel_value;
   logic [7:0]  entry_index;
   logic [15:0] red_in;
   logic [15:0] green_in;
   logic [15:0] blue_in;

   modport source (output valid, kind, pixel_value, entry_index, red_in, green_in, blue_in,
                   input ready);
   modport sink   (input valid, kind, pixel_value, entry_index, red_in, green_in, blue_in,
                   output ready);
endinterface

interface p2rgb_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] red_out;
   logic [7:0] green_out;
   logic [7:0] blue_out;
   logic       index_error;

   modport source (output valid, red_out, green_out, blue_out, index_error, input ready);
   modport sink   (input valid, red_out, green_out, blue_out, index_error, output ready);
endinterface

// ===== hw/rtl/pixel_to_rgb_converter_unit.sv =====
// Pixel to RGB888 converter, top level: direct mask scaling and palette lookup.
// Depends on p2rgb_pkg and the interfaces in p2rgb_if.sv.
//
// Usage:
//  - req_ch carries one item per handshake: kind 0 converts pixel_value,
//    kind 1 writes palette entry entry_index with the top bytes of
//    red_in/green_in/blue_in. Every item yields exactly one rsp_ch item.
//  - csr_we/csr_index/csr_wdata write the configuration registers; write
//    only while no item is in flight. Mask writes precompute shift, field
//    maximum and scale in the same cycle, so a pixel may follow at once.
//  - Throughput: one item per clock while rsp_ch takes results. The read
//    stage loads at the accepting edge and the output register once it is
//    free, so a stall on rsp_ch can hold the result in the read stage.
//    The registered palette memory read sets the stage count.
//  - Palette writes land at their accept edge; a pixel accepted in the next
//    cycle already reads the new entry.
//  - Reset (synchronous) restores the register reset values and marks every
//    palette entry unwritten; unwritten entries read black, entry 1 white.
//    No clearing pass is needed.
//  - When rsp_ch stalls, the output register and the read stage hold;
//    req_ch.ready drops only when both are full.
module pixel_to_rgb_converter_unit (
   input  logic                                   clock,
   input  logic                                   reset,
   p2rgb_req_if.sink                              req_ch,
   p2rgb_rsp_if.source                            rsp_ch,
   input  logic                                   csr_we,
   input  logic [p2rgb_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [p2rgb_pkg::CSR_DATA_W-1:0]       csr_wdata
);

   localparam int IDX_W = p2rgb_pkg::PAL_IDX_W;
   localparam int CNT_W = p2rgb_pkg::PAL_CNT_W;

   // ---------------------------------------------------------------------
   // 255 / top table, built at elaboration. Entry 0 gives 0 (zero mask).
   // ---------------------------------------------------------------------
   logic [7:0] scale_lut [256];
   for (genvar g = 0; g < 256; g++) begin : g_scale_lut
      localparam int QUOT = (g == 0) ? 0 : 255 / g;
      assign scale_lut[g] = 8'(QUOT);
   end

   // ---------------------------------------------------------------------
   // Configuration
   // ---------------------------------------------------------------------
   logic                        direct_mode_ff;
   p2rgb_pkg::chan_cfg_type     red_chan_ff, green_chan_ff, blue_chan_ff;
   logic [CNT_W-1:0]            entries_ff;

   p2rgb_pkg::chan_cfg_type     csr_chan_in;
   logic [CNT_W-1:0]            entries_in;

   // Trailing zero count by halving steps; the residue is the field maximum.
   always_comb begin
      logic [31:0] v;
      logic [4:0]  s;
      v = csr_wdata;
      s = 5'd0;
      if (v[15:0] == 16'h0) begin
         v = v >> 16;
         s = s + 5'd16;
      end
      if (v[7:0] == 8'h0) begin
         v = v >> 8;
         s = s + 5'd8;
      end
      if (v[3:0] == 4'h0) begin
         v = v >> 4;
         s = s + 5'd4;
      end
      if (v[1:0] == 2'h0) begin
         v = v >> 2;
         s = s + 5'd2;
      end
      if (v[0] == 1'b0) begin
         v = v >> 1;
         s = s + 5'd1;
      end
      csr_chan_in.shift = s;
      csr_chan_in.top   = v[7:0];
      // field maximum above 255 scales to zero
      csr_chan_in.scale = (v[31:8] != 24'h0) ? 8'd0 : scale_lut[v[7:0]];
   end

   // Entries in use: 0 means the two-entry map, capped at the palette depth.
   always_comb begin
      logic [31:0] cc;
      cc = 32'(csr_wdata[8:0]);
      if (cc == 32'd0) begin
         entries_in = CNT_W'(2);
      end else if (cc > 32'(p2rgb_pkg::PALETTE_DEPTH)) begin
         entries_in = CNT_W'(p2rgb_pkg::PALETTE_DEPTH);
      end else begin
         entries_in = cc[CNT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         direct_mode_ff <= 1'b1;
         red_chan_ff    <= p2rgb_pkg::RED_CHAN_RESET;
         green_chan_ff  <= p2rgb_pkg::GREEN_CHAN_RESET;
         blue_chan_ff   <= p2rgb_pkg::BLUE_CHAN_RESET;
         entries_ff     <= CNT_W'(2);
      end else if (csr_we) begin
         case (csr_index)
            p2rgb_pkg::CSR_DIRECT_MODE: direct_mode_ff <= csr_wdata[0];
            p2rgb_pkg::CSR_RED_FIELD:   red_chan_ff    <= csr_chan_in;
            p2rgb_pkg::CSR_GREEN_FIELD: green_chan_ff  <= csr_chan_in;
            p2rgb_pkg::CSR_BLUE_FIELD:  blue_chan_ff   <= csr_chan_in;
            p2rgb_pkg::CSR_COLOR_COUNT: entries_ff     <= entries_in;
            default: ;
         endcase
      end
   end

   // ---------------------------------------------------------------------
   // Handshake: read stage (s1) feeding the output register.
   // ---------------------------------------------------------------------
   logic s1_valid_ff, out_valid_ff;
   logic out_free, s1_adv, accept;

   assign out_free     = !out_valid_ff || rsp_ch.ready;
   assign s1_adv       = s1_valid_ff && out_free;
   assign req_ch.ready = !s1_valid_ff || out_free;
   assign accept       = req_ch.valid && req_ch.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            s1_valid_ff <= 1'b1;
         end else if (s1_adv) begin
            s1_valid_ff <= 1'b0;
         end
         if (s1_adv) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_ch.ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   // ---------------------------------------------------------------------
   // Accept stage: range checks, palette write, palette read, field extract.
   // ---------------------------------------------------------------------
   logic [31:0]      pix_idx32, wr_idx32, entries32;
   logic [IDX_W-1:0] rd_addr, wr_addr;
   logic             pix_in_range, wr_in_range, do_write;
   p2rgb_pkg::rgb_type wr_color;

   assign entries32    = 32'(entries_ff);
   assign pix_idx32    = req_ch.pixel_value;
   assign wr_idx32     = 32'(req_ch.entry_index);
   assign rd_addr      = pix_idx32[IDX_W-1:0];
   assign wr_addr      = wr_idx32[IDX_W-1:0];
   assign pix_in_range = pix_idx32 < entries32;
   assign wr_in_range  = wr_idx32 < entries32;
   assign do_write     = accept && req_ch.kind && wr_in_range;
   assign wr_color     = '{red:   req_ch.red_in[15:8],
                           green: req_ch.green_in[15:8],
                           blue:  req_ch.blue_in[15:8]};

   // Channel field: (pixel >> shift) & top, only the low byte can survive.
   function automatic logic [7:0] extract_field(input logic [31:0] pixel,
                                                input p2rgb_pkg::chan_cfg_type chan);
      logic [31:0] shifted;
      shifted = pixel >> chan.shift;
      return shifted[7:0] & chan.top;
   endfunction

   // Palette store with per-entry written flags; unwritten entries read
   // as their reset color.
   p2rgb_pkg::rgb_type pal_mem [p2rgb_pkg::PALETTE_DEPTH];
   logic [p2rgb_pkg::PALETTE_DEPTH-1:0] pal_valid_ff;

   always_ff @(posedge clock) begin
      if (do_write) begin
         pal_mem[wr_addr] <= wr_color;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pal_valid_ff <= '0;
      end else if (do_write) begin
         pal_valid_ff[wr_addr] <= 1'b1;
      end
   end

   p2rgb_pkg::rgb_type rd_data_ff;
   logic               rd_valid_ff, rd_is_one_ff;
   logic               s1_kind_ff, s1_in_range_ff;
   logic [7:0]         s1_red_field_ff, s1_green_field_ff, s1_blue_field_ff;

   always_ff @(posedge clock) begin
      if (accept) begin
         rd_data_ff        <= pal_mem[rd_addr];
         rd_valid_ff       <= pal_valid_ff[rd_addr];
         rd_is_one_ff      <= (rd_addr == IDX_W'(1));
         s1_kind_ff        <= req_ch.kind;
         s1_in_range_ff    <= req_ch.kind ? wr_in_range : pix_in_range;
         s1_red_field_ff   <= extract_field(req_ch.pixel_value, red_chan_ff);
         s1_green_field_ff <= extract_field(req_ch.pixel_value, green_chan_ff);
         s1_blue_field_ff  <= extract_field(req_ch.pixel_value, blue_chan_ff);
      end
   end

   // ---------------------------------------------------------------------
   // Read stage: scale multiply or palette select into the output register.
   // ---------------------------------------------------------------------
   logic [15:0]        red_prod, green_prod, blue_prod;
   p2rgb_pkg::rgb_type pal_color, out_color_in;
   logic               out_error_in;

   assign red_prod   = 16'(s1_red_field_ff)   * 16'(red_chan_ff.scale);
   assign green_prod = 16'(s1_green_field_ff) * 16'(green_chan_ff.scale);
   assign blue_prod  = 16'(s1_blue_field_ff)  * 16'(blue_chan_ff.scale);

   always_comb begin
      if (rd_valid_ff) begin
         pal_color = rd_data_ff;
      end else if (rd_is_one_ff) begin
         pal_color = p2rgb_pkg::RGB_WHITE;
      end else begin
         pal_color = p2rgb_pkg::RGB_BLACK;
      end
   end

   always_comb begin
      out_color_in = p2rgb_pkg::RGB_BLACK;
      out_error_in = 1'b0;
      if (s1_kind_ff) begin
         out_error_in = !s1_in_range_ff;
      end else if (direct_mode_ff) begin
         out_color_in = '{red: red_prod[7:0], green: green_prod[7:0], blue: blue_prod[7:0]};
      end else if (s1_in_range_ff) begin
         out_color_in = pal_color;
      end else begin
         out_error_in = 1'b1;
      end
   end

   p2rgb_pkg::rgb_type out_color_ff;
   logic               out_error_ff;

   always_ff @(posedge clock) begin
      if (s1_adv) begin
         out_color_ff <= out_color_in;
         out_error_ff <= out_error_in;
      end
   end

   assign rsp_ch.valid       = out_valid_ff;
   assign rsp_ch.red_out     = out_color_ff.red;
   assign rsp_ch.green_out   = out_color_ff.green;
   assign rsp_ch.blue_out    = out_color_ff.blue;
   assign rsp_ch.index_error = out_error_ff;

endmodule

// ===== tb/tb_pixel_to_rgb_converter_unit.sv =====
// Self-checking testbench for pixel_to_rgb_converter_unit: directed table, then
// randomized phases over several register settings. Depends on p2rgb_pkg and p2rgb_if.sv.
`timescale 1ns / 1ps

module tb_pixel_to_rgb_converter_unit;

   localparam int N_PHASES        = 10;
   localparam int ITEMS_PER_PHASE = 55;
   localparam int PRESSURE_PHASE  = 4;      // runs with no idling on either side
   localparam int HOLD_CYCLES     = 64;     // long receiver hold-off
   localparam int DRAIN_CYCLES    = 4;      // two-stage pipe plus margin
   localparam int TIMEOUT_NS      = 2_000_000;
   localparam int MAX_REPORTS     = 10;
   localparam int DEPTH           = p2rgb_pkg::PALETTE_DEPTH;

   // short names for the register codes, used in the directed table
   localparam p2rgb_pkg::csr_reg_type R_MODE  = p2rgb_pkg::CSR_DIRECT_MODE;
   localparam p2rgb_pkg::csr_reg_type R_RED   = p2rgb_pkg::CSR_RED_FIELD;
   localparam p2rgb_pkg::csr_reg_type R_GREEN = p2rgb_pkg::CSR_GREEN_FIELD;
   localparam p2rgb_pkg::csr_reg_type R_BLUE  = p2rgb_pkg::CSR_BLUE_FIELD;
   localparam p2rgb_pkg::csr_reg_type R_COUNT = p2rgb_pkg::CSR_COLOR_COUNT;

   typedef enum logic {KIND_PIXEL = 1'b0, KIND_PALETTE = 1'b1} item_kind_type;
   typedef enum logic [1:0] {ROW_PIXEL, ROW_PAL_WRITE, ROW_CSR} row_op_type;

   typedef struct packed {
      item_kind_type kind;
      logic [31:0]   pixel_value;
      logic [7:0]    entry_index;
      logic [15:0]   red_in;
      logic [15:0]   green_in;
      logic [15:0]   blue_in;
   } pix_req_type;

   typedef struct packed {
      p2rgb_pkg::rgb_type rgb;
      logic               index_error;
   } rgb_result_type;

   typedef struct packed {
      logic        direct_mode;
      logic [31:0] red_field;
      logic [31:0] green_field;
      logic [31:0] blue_field;
      logic [8:0]  color_count;
   } conv_cfg_type;

   // One row of the directed table. data is the pixel word or the register
   // value; csr is only looked at on register rows.
   typedef struct packed {
      row_op_type             op;
      p2rgb_pkg::csr_reg_type csr;
      logic [31:0]            data;
      logic [7:0]             entry;
      logic [15:0]            red;
      logic [15:0]            green;
      logic [15:0]            blue;
      logic                   typed;
      logic [23:0]            want_rgb;
      logic                   want_err;
   } dir_row_type;

   localparam int N_DIRECTED = 34;
   localparam dir_row_type DIRECTED [N_DIRECTED] = '{
      // reset masks: plain 8:8:8 unpacking, extremes of the pixel word
      '{ROW_PIXEL, R_MODE, 32'h00FF8001, 8'd0, 16'h0, 16'h0, 16'h0, 1'b1, 24'hFF8001, 1'b0},
      '{ROW_PIXEL, R_MODE, 32'hFFFFFFFF, 8'd0, 16'h0, 16'h0, 16'h0, 1'b1, 24'hFFFFFF, 1'b0},
      '{ROW_PIXEL, R_MODE, 32'h00000000, 8'd0, 16'h0, 16'h0, 16'h0, 1'b1, 24'h000000, 1'b0},
      // palette writes in direct mode; two-entry map after reset
      '{ROW_PAL_WRITE, R_MODE, 32'h0, 8'd0, 16'hFFFF, 16'h1234, 16'h00FF, 1'b1, 24'h0, 1'b0},
      '{ROW_PAL_WRITE, R_MODE, 32'h0, 8'd2, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1, 24'h0, 1'b1},
      '{ROW_PAL_WRITE, R_MODE, 32'h0, 8'd255, 16'h0, 16'h0, 16'h0, 1'b1, 24'h0, 1'b1},
      '{ROW_CSR,   R_MODE, 32'h0,        8'd0, 16'h0, 16'h0, 16'h0, 1'b0, 24'h0,      1'b0},
      '{ROW_PIXEL, R_MODE, 32'h00000000, 8'd0, 16'h0, 16'h0, 16'h0, 1'b0, 24'h0,      1'b0},
      '{ROW_PIXEL, R_MODE, 32'h00000001, 8'd0, 16'h0, 16'h0, 16'h0, 1'b1, 24'hFFFFFF, 1'b0},
      '{ROW_PIXEL, R_MODE, 32'h00000002, 8'd0, 16'h0, 16'h0, 16'h0, 1'b1, 24'h000000, 1'b1},
      '{ROW_PIXEL, R_MODE, 32'hFFFFFFFF, 8'd0, 16'h0, 16'h0, 16'h0, 1'b1, 24'h000000, 1'b1},
      // full palette
      '{ROW_CSR,   R_COUNT, 32'd256, 8'd0, 16'h0, 16'h0, 16'h0, 1'b0, 24'h0, 1'b0},
      '{ROW_PAL_WRITE, R_MODE, 32'h0, 8'd255, 16'hABCD, 16'h0080, 16'hFF00, 1'b1, 24'h0, 1'b0},
      '{ROW_PIXEL, R_MODE, 32'd255, 8'd0, 16'h0, 16'h0, 16'h0, 1'b0, 24'h0,      1'b0},
      '{ROW_PIXEL, R_MODE, 32'd256, 8'd0, 16'h0, 16'h0, 16'h0, 1'b1, 24'h000000, 1'b1},
      '{ROW_PIXEL, R_MODE, 32'd200, 8'd0, 16'h0, 16'h0, 16'h0, 1'b1, 24'h000000, 1'b0},
      // single-entry palette
      '{ROW_CSR,   R_COUNT, 32'd1, 8'd0, 16'h0, 16'h0, 16'h0, 1'b0, 24'h0,      1'b0},
      '{ROW_PIXEL, R_MODE,  32'd1, 8'd0, 16'h0, 16'h0, 16'h0, 1'b1, 24'h000000, 1'b1},
      '{ROW_PAL_WRITE, R_MODE, 32'h0, 8'd1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1, 24'h0, 1'b1},
      '{ROW_PIXEL, R_MODE,  32'd0, 8'd0, 16'h0, 16'h0, 16'h0, 1'b0, 24'h0,      1'b0},
      // zero mask, top-bit mask, gapped mask
      '{ROW_CSR,   R_MODE,  32'h1,        8'd0, 16'h0, 16'h0, 16'h0, 1'b0, 24'h0, 1'b0},
      '{ROW_CSR,   R_RED,   32'h00000000, 8'd0, 16'h0, 16'h0, 16'h0, 1'b0, 24'h0, 1'b0},
      '{ROW_CSR,   R_GREEN, 32'h80000000, 8'd0, 16'h0, 16'h0, 16'h0, 1'b0, 24'h0, 1'b0},
      '{ROW_CSR,   R_BLUE,  32'h000000A0, 8'd0, 16'h0, 16'h0, 16'h0, 1'b0, 24'h0, 1'b0},
      '{ROW_PIXEL, R_MODE,  32'hFFFFFFFF, 8'd0, 16'h0, 16'h0, 16'h0, 1'b0, 24'h0, 1'b0},
      '{ROW_PIXEL, R_MODE,  32'h80000020, 8'd0, 16'h0, 16'h0, 16'h0, 1'b0, 24'h0, 1'b0},
      // field wider than 8 bits, odd-width field, all-ones mask
      '{ROW_CSR,   R_RED,   32'h000001FF, 8'd0, 16'h0, 16'h0, 16'h0, 1'b0, 24'h0, 1'b0},
      '{ROW_CSR,   R_GREEN, 32'h0000000E, 8'd0, 16'h0, 16'h0, 16'h0, 1'b0, 24'h0, 1'b0},
      '{ROW_CSR,   R_BLUE,  32'hFFFFFFFF, 8'd0, 16'h0, 16'h0, 16'h0, 1'b0, 24'h0, 1'b0},
      '{ROW_PIXEL, R_MODE,  32'hFFFFFFFF, 8'd0, 16'h0, 16'h0, 16'h0, 1'b0, 24'h0, 1'b0},
      '{ROW_PIXEL, R_MODE,  32'h0000000A, 8'd0, 16'h0, 16'h0, 16'h0, 1'b0, 24'h0, 1'b0},
      // write in direct mode, then read it back through the palette
      '{ROW_PAL_WRITE, R_MODE, 32'h0, 8'd0, 16'h0000, 16'hFFFF, 16'h8000, 1'b1, 24'h0, 1'b0},
      '{ROW_CSR,   R_MODE,  32'h0,        8'd0, 16'h0, 16'h0, 16'h0, 1'b0, 24'h0, 1'b0},
      '{ROW_PIXEL, R_MODE,  32'd0,        8'd0, 16'h0, 16'h0, 16'h0, 1'b0, 24'h0, 1'b0}
   };

   logic clock = 1'b0;
   logic reset;
   logic csr_we;
   logic [p2rgb_pkg::CSR_IDX_W-1:0]  csr_index;
   logic [p2rgb_pkg::CSR_DATA_W-1:0] csr_wdata;

   p2rgb_req_if req_ch ();
   p2rgb_rsp_if rsp_ch ();

   pixel_to_rgb_converter_unit u_top (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Watchdog: a hung handshake or a lost result ends here.
   initial begin
      #(TIMEOUT_NS);
      $display("status: fail");
      $finish;
   end

   // ---------------------------------------------------------------------
   // Predictor state: its own copy of the registers and the three palettes.
   // ---------------------------------------------------------------------
   conv_cfg_type   conv_cfg;
   logic [7:0]     pal_red   [DEPTH];
   logic [7:0]     pal_green [DEPTH];
   logic [7:0]     pal_blue  [DEPTH];
   rgb_result_type rgb_expected_q [$];

   int unsigned send_idle_pct;
   int unsigned recv_stall_pct;
   int unsigned hold_reqs;
   int unsigned mismatches;
   int unsigned pixels_sent;
   int unsigned pal_writes_sent;
   int unsigned range_errors;
   int unsigned csr_writes;
   int unsigned input_stalls;

   function automatic void reset_model();
      conv_cfg = '{direct_mode: 1'b1, red_field: 32'h00FF0000, green_field: 32'h0000FF00,
                   blue_field: 32'h000000FF, color_count: 9'd0};
      for (int i = 0; i < DEPTH; i++) begin
         pal_red[i]   = 8'h00;
         pal_green[i] = 8'h00;
         pal_blue[i]  = 8'h00;
      end
      // entry 1 powers up white so the default two-entry map is black/white
      pal_red[1]   = 8'hFF;
      pal_green[1] = 8'hFF;
      pal_blue[1]  = 8'hFF;
   endfunction

   // Entries in use: a zero count means the two-entry map.
   function automatic int unsigned palette_entries();
      int unsigned n;
      n = (conv_cfg.color_count == 0) ? 2 : conv_cfg.color_count;
      if (n > DEPTH)
         n = DEPTH;
      return n;
   endfunction

   // Shift = trailing zeros of the mask; top = mask >> shift, gaps kept.
   // A top above 255 makes the integer scale zero, so the channel reads 0.
   function automatic logic [7:0] scaled_channel(logic [31:0] pixel, logic [31:0] mask);
      int unsigned shift;
      logic [31:0] top;
      logic [31:0] field;
      logic [31:0] scale;
      if (mask == 32'h0)
         return 8'h00;
      shift = 0;
      while (shift < 31 && mask[shift] == 1'b0)
         shift++;
      top   = mask >> shift;
      scale = 32'd255 / top;
      field = (pixel >> shift) & top;
      return 8'(field * scale);
   endfunction

   // Expected result of one accepted item; palette writes update the model.
   function automatic rgb_result_type predict_rgb(pix_req_type it);
      rgb_result_type r;
      int unsigned n;
      r = '0;
      n = palette_entries();
      if (it.kind == KIND_PALETTE) begin
         if (it.entry_index < n) begin
            pal_red[it.entry_index]   = it.red_in[15:8];
            pal_green[it.entry_index] = it.green_in[15:8];
            pal_blue[it.entry_index]  = it.blue_in[15:8];
         end else begin
            r.index_error = 1'b1;
         end
      end else if (conv_cfg.direct_mode) begin
         r.rgb.red   = scaled_channel(it.pixel_value, conv_cfg.red_field);
         r.rgb.green = scaled_channel(it.pixel_value, conv_cfg.green_field);
         r.rgb.blue  = scaled_channel(it.pixel_value, conv_cfg.blue_field);
      end else if (it.pixel_value < n) begin
         r.rgb.red   = pal_red[it.pixel_value[7:0]];
         r.rgb.green = pal_green[it.pixel_value[7:0]];
         r.rgb.blue  = pal_blue[it.pixel_value[7:0]];
      end else begin
         r.index_error = 1'b1;
      end
      return r;
   endfunction

   // ---------------------------------------------------------------------
   // Random stimulus
   // ---------------------------------------------------------------------
   // Mostly contiguous fields of up to 8 bits; also empty, full, single-bit,
   // gapped, wide and fully random masks.
   function automatic logic [31:0] random_mask();
      int unsigned width;
      int unsigned pos;
      logic [31:0] m;
      case ($urandom_range(9))
         0: m = 32'h0;
         1: m = 32'hFFFFFFFF;
         2: m = 32'h1 << $urandom_range(31);
         3, 4, 5, 6: begin
            width = $urandom_range(1, 8);
            pos   = $urandom_range(32 - width);
            m     = ((32'h1 << width) - 1) << pos;
         end
         7: m = 32'($urandom_range(255)) << $urandom_range(24);
         8: m = $urandom();
         default: begin
            width = $urandom_range(9, 16);
            pos   = $urandom_range(32 - width);
            m     = ((32'h1 << width) - 1) << pos;
         end
      endcase
      return m;
   endfunction

   // Well-formed traffic dominates: writes and palette reads mostly land
   // inside the palette in use, with a tail of out-of-range indexes.
   function automatic pix_req_type random_item();
      pix_req_type it;
      int unsigned n;
      n = palette_entries();
      it.kind        = ($urandom_range(99) < 30) ? KIND_PALETTE : KIND_PIXEL;
      it.pixel_value = $urandom();
      it.entry_index = 8'($urandom_range(255));
      it.red_in      = 16'($urandom_range(65535));
      it.green_in    = 16'($urandom_range(65535));
      it.blue_in     = 16'($urandom_range(65535));
      if (it.kind == KIND_PALETTE) begin
         if ($urandom_range(99) < 85)
            it.entry_index = 8'($urandom_range(n - 1));
      end else if (!conv_cfg.direct_mode) begin
         case ($urandom_range(9))
            0: ;                                            // any word
            1: it.pixel_value = n + $urandom_range(3);      // just past the end
            default: it.pixel_value = $urandom_range(n - 1);
         endcase
      end else if ($urandom_range(19) == 0) begin
         it.pixel_value = $urandom_range(1) ? 32'hFFFFFFFF : 32'h0;
      end
      return it;
   endfunction

   // ---------------------------------------------------------------------
   // Drivers. Every NBA happens right after a rising edge, and no signal
   // gets two NBAs in one step.
   // ---------------------------------------------------------------------
   task automatic send_item(input pix_req_type it, input bit use_typed,
                            input rgb_result_type typed_result);
      rgb_result_type predicted;
      while ($urandom_range(99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid       <= 1'b1;
      req_ch.kind        <= it.kind;
      req_ch.pixel_value <= it.pixel_value;
      req_ch.entry_index <= it.entry_index;
      req_ch.red_in      <= it.red_in;
      req_ch.green_in    <= it.green_in;
      req_ch.blue_in     <= it.blue_in;
      do
         @(posedge clock);
      while (!req_ch.ready);
      // accepted at this edge; predictor sees items in accept order
      predicted = predict_rgb(it);
      rgb_expected_q.push_back(use_typed ? typed_result : predicted);
      if (it.kind == KIND_PALETTE)
         pal_writes_sent++;
      else
         pixels_sent++;
      if (predicted.index_error)
         range_errors++;
   endtask

   // Every item gives one result, so an empty queue plus the pipe depth
   // means nothing is in flight.
   task automatic wait_idle();
      req_ch.valid <= 1'b0;
      while (rgb_expected_q.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input p2rgb_pkg::csr_reg_type idx, input logic [31:0] data);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      case (idx)
         p2rgb_pkg::CSR_DIRECT_MODE: conv_cfg.direct_mode = data[0];
         p2rgb_pkg::CSR_RED_FIELD:   conv_cfg.red_field   = data;
         p2rgb_pkg::CSR_GREEN_FIELD: conv_cfg.green_field = data;
         p2rgb_pkg::CSR_BLUE_FIELD:  conv_cfg.blue_field  = data;
         p2rgb_pkg::CSR_COLOR_COUNT: conv_cfg.color_count = data[8:0];
         default: ;
      endcase
      csr_writes++;
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   // ---------------------------------------------------------------------
   // Receiver pacing: random stalls per phase, plus a long hold-off on
   // request so the two pipe stages fill and req ready drops.
   // ---------------------------------------------------------------------
   initial begin : rsp_pacer
      int unsigned hold_left;
      int unsigned hold_seen;
      hold_left = 0;
      hold_seen = 0;
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (reset) begin
            rsp_ch.ready <= 1'b0;
         end else if (hold_seen != hold_reqs) begin
            hold_seen = hold_reqs;
            hold_left = HOLD_CYCLES;
            rsp_ch.ready <= 1'b0;
         end else if (hold_left != 0) begin
            hold_left--;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
         end
      end
   end

   // ---------------------------------------------------------------------
   // Result checker: oldest expectation against each accepted result.
   // ---------------------------------------------------------------------
   task automatic note_mismatch(input string what, input rgb_result_type want,
                                input rgb_result_type got);
      mismatches++;
      if (mismatches <= MAX_REPORTS)
         $display("%0t: %s: expected r=%02h g=%02h b=%02h err=%0b, %s",
                  $time, what, want.rgb.red, want.rgb.green, want.rgb.blue,
                  want.index_error,
                  $sformatf("got r=%02h g=%02h b=%02h err=%0b",
                            got.rgb.red, got.rgb.green, got.rgb.blue,
                            got.index_error));
   endtask

   initial begin : rsp_checker
      rgb_result_type got;
      rgb_result_type want;
      forever begin
         @(posedge clock);
         if (!reset) begin
            if (req_ch.valid && !req_ch.ready)
               input_stalls++;
            if (rsp_ch.valid && rsp_ch.ready) begin
               got.rgb.red     = rsp_ch.red_out;
               got.rgb.green   = rsp_ch.green_out;
               got.rgb.blue    = rsp_ch.blue_out;
               got.index_error = rsp_ch.index_error;
               if (rgb_expected_q.size() == 0) begin
                  note_mismatch("result with no item pending", '0, got);
               end else begin
                  want = rgb_expected_q.pop_front();
                  if (got.rgb.red !== want.rgb.red || got.rgb.green !== want.rgb.green ||
                      got.rgb.blue !== want.rgb.blue ||
                      got.index_error !== want.index_error)
                     note_mismatch("result mismatch", want, got);
               end
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // Main sequence
   // ---------------------------------------------------------------------
   initial begin : stimulus
      dir_row_type    row;
      pix_req_type    it;
      rgb_result_type typed;
      int unsigned    cc;

      reset              <= 1'b1;
      req_ch.valid       <= 1'b0;
      req_ch.kind        <= KIND_PIXEL;
      req_ch.pixel_value <= 32'h0;
      req_ch.entry_index <= 8'h0;
      req_ch.red_in      <= 16'h0;
      req_ch.green_in    <= 16'h0;
      req_ch.blue_in     <= 16'h0;
      csr_we             <= 1'b0;
      csr_index          <= p2rgb_pkg::CSR_DIRECT_MODE;
      csr_wdata          <= '0;
      send_idle_pct   = 0;
      recv_stall_pct  = 0;
      hold_reqs       = 0;
      mismatches      = 0;
      pixels_sent     = 0;
      pal_writes_sent = 0;
      range_errors    = 0;
      csr_writes      = 0;
      input_stalls    = 0;
      reset_model();

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Directed table, no idling. Register rows wait for the pipe to drain.
      for (int i = 0; i < N_DIRECTED; i++) begin
         row = DIRECTED[i];
         if (row.op == ROW_CSR) begin
            wait_idle();
            write_csr(row.csr, row.data);
         end else begin
            it.kind        = (row.op == ROW_PAL_WRITE) ? KIND_PALETTE : KIND_PIXEL;
            it.pixel_value = row.data;
            it.entry_index = row.entry;
            it.red_in      = row.red;
            it.green_in    = row.green;
            it.blue_in     = row.blue;
            typed.rgb         = p2rgb_pkg::rgb_type'(row.want_rgb);
            typed.index_error = row.want_err;
            send_item(it, row.typed, typed);
         end
      end

      // Random phases: each gets fresh settings for every register and its
      // own pacing (none, sender idle, receiver stall, both).
      for (int p = 0; p < N_PHASES; p++) begin
         wait_idle();
         case (p % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct <= 0;  end
            1: begin send_idle_pct = 78; recv_stall_pct <= 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct <= 78; end
            default: begin send_idle_pct = 15; recv_stall_pct <= 15; end
         endcase
         case (p % 5)
            0: cc = 0;
            1: cc = DEPTH;
            2: cc = 1;
            3: cc = DEPTH - 1;
            default: cc = $urandom_range(2, DEPTH - 2);
         endcase
         write_csr(p2rgb_pkg::CSR_DIRECT_MODE, (p % 2 == 0) ? 32'h1 : 32'h0);
         write_csr(p2rgb_pkg::CSR_COLOR_COUNT, cc);
         if (p == 1) begin
            // mask extremes: empty, full, top bit alone
            write_csr(p2rgb_pkg::CSR_RED_FIELD, 32'h0);
            write_csr(p2rgb_pkg::CSR_GREEN_FIELD, 32'hFFFFFFFF);
            write_csr(p2rgb_pkg::CSR_BLUE_FIELD, 32'h80000000);
         end else begin
            write_csr(p2rgb_pkg::CSR_RED_FIELD, random_mask());
            write_csr(p2rgb_pkg::CSR_GREEN_FIELD, random_mask());
            write_csr(p2rgb_pkg::CSR_BLUE_FIELD, random_mask());
         end
         // back-pressure: receiver holds off while items keep coming
         if (p == PRESSURE_PHASE)
            hold_reqs <= hold_reqs + 1;
         repeat (ITEMS_PER_PHASE)
            send_item(random_item(), 1'b0, '0);
      end

      wait_idle();

      $display("ran %0d items: %0d pixel conversions, %0d palette writes, %0d out of range",
               pixels_sent + pal_writes_sent, pixels_sent, pal_writes_sent, range_errors);
      $display("over %0d register writes, %0d input stall cycles, %0d mismatches",
               csr_writes, input_stalls, mismatches);
      if (mismatches == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule
